// ----- hw/rtl/gcb_pkg.sv -----
package gcb_pkg;

  // field widths
  localparam int COORD_W      = 24;
  localparam int CHUNK_REG_W  = 4;
  localparam int SUB_REG_W    = 3;
  localparam int EDGE_W       = 23;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 23;
  localparam int CHUNK_SLOT_W = 9;
  localparam int SUB_SLOT_W   = 6;

  // default grid capacity
  localparam int DEF_MAX_CHUNK_AXIS = 8;
  localparam int DEF_MAX_SUB_AXIS   = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUBS_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUBS_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUBS_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_EDGE = 3'd6;

  // register reset values
  localparam logic [CHUNK_REG_W-1:0] RST_CHUNKS_X = 4'd5;
  localparam logic [CHUNK_REG_W-1:0] RST_CHUNKS_Y = 4'd1;
  localparam logic [CHUNK_REG_W-1:0] RST_CHUNKS_Z = 4'd5;
  localparam logic [SUB_REG_W-1:0]   RST_SUBS_X   = 3'd4;
  localparam logic [SUB_REG_W-1:0]   RST_SUBS_Y   = 3'd2;
  localparam logic [SUB_REG_W-1:0]   RST_SUBS_Z   = 3'd4;
  localparam logic [EDGE_W-1:0]      RST_CELL_EDGE = 23'd25600;

  // request modes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CHUNK_REG_W-1:0] chunks_x;
    logic [CHUNK_REG_W-1:0] chunks_y;
    logic [CHUNK_REG_W-1:0] chunks_z;
    logic [SUB_REG_W-1:0]   subs_x;
    logic [SUB_REG_W-1:0]   subs_y;
    logic [SUB_REG_W-1:0]   subs_z;
    logic [EDGE_W-1:0]      cell_edge;
  } grid_cfg_t;

  typedef struct packed {
    logic                      mode;
    logic                      has_mesh;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] box_lo_x;
    logic signed [COORD_W-1:0] box_lo_y;
    logic signed [COORD_W-1:0] box_lo_z;
    logic signed [COORD_W-1:0] box_hi_x;
    logic signed [COORD_W-1:0] box_hi_y;
    logic signed [COORD_W-1:0] box_hi_z;
  } in_item_t;

  typedef struct packed {
    logic                      accepted;
    logic [CHUNK_SLOT_W-1:0]   chunk_slot;
    logic [SUB_SLOT_W-1:0]     sub_slot;
    logic                      cell_empty;
    logic signed [COORD_W-1:0] cell_lo_x;
    logic signed [COORD_W-1:0] cell_lo_y;
    logic signed [COORD_W-1:0] cell_lo_z;
    logic signed [COORD_W-1:0] cell_hi_x;
    logic signed [COORD_W-1:0] cell_hi_y;
    logic signed [COORD_W-1:0] cell_hi_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_z;
  } box_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                    acc;
    logic                    add;
    logic [CHUNK_SLOT_W-1:0] cslot;
    logic [SUB_SLOT_W-1:0]   sslot;
    box_t                    box;
  } cls_t;

  // one subcell entry of the box memory
  typedef struct packed {
    logic used;
    box_t box;
  } cell_ent_t;

endpackage

// ----- hw/rtl/gcb_front.sv -----
module gcb_front
  import gcb_pkg::*;
#(
  parameter int MAX_CHUNK_AXIS = DEF_MAX_CHUNK_AXIS,
  parameter int MAX_SUB_AXIS   = DEF_MAX_SUB_AXIS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  grid_cfg_t cfg,
  input  logic      start_acc,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      push,
  output cls_t      push_data,
  output logic [((MAX_CHUNK_AXIS**3)*(MAX_SUB_AXIS**3) > 1 ?
                 $clog2((MAX_CHUNK_AXIS**3)*(MAX_SUB_AXIS**3)) : 1)-1:0] push_idx,
  input  logic      q_full
);

  localparam int NCW       = $clog2(MAX_CHUNK_AXIS + 1);
  localparam int SCW       = $clog2(MAX_SUB_AXIS + 1);
  localparam int CHUNK_CAP = MAX_CHUNK_AXIS ** 3;
  localparam int SUB_CAP   = MAX_SUB_AXIS ** 3;
  localparam int CELL_CAP  = CHUNK_CAP * SUB_CAP;
  localparam int CSW       = CHUNK_CAP > 1 ? $clog2(CHUNK_CAP) : 1;
  localparam int SSW       = SUB_CAP > 1 ? $clog2(SUB_CAP) : 1;
  localparam int AW        = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;
  localparam int RW        = (COORD_W - 1) > EDGE_W ? (COORD_W - 1) : EDGE_W;
  localparam int XW        = RW + SCW;

  typedef enum logic [7:0] {
    F_IDLE  = 8'b0000_0001,
    F_CHUNK = 8'b0000_0010,
    F_SCALE = 8'b0000_0100,
    F_SUB   = 8'b0000_1000,
    F_SLOT1 = 8'b0001_0000,
    F_SLOT2 = 8'b0010_0000,
    F_IDX   = 8'b0100_0000,
    F_PUSH  = 8'b1000_0000
  } fst_t;

  fst_t           st_r, st_nxt;
  in_item_t       item_r, item_nxt;
  logic           rej_r, rej_nxt;
  logic [XW-1:0]  rem_r [3];
  logic [XW-1:0]  rem_nxt [3];
  logic [NCW-1:0] c_r [3];
  logic [NCW-1:0] c_nxt [3];
  logic [SCW-1:0] q_r [3];
  logic [SCW-1:0] q_nxt [3];
  logic [CSW-1:0] t_r, t_nxt, cslot_r, cslot_nxt;
  logic [SSW-1:0] u_r, u_nxt, sslot_r, sslot_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;

  logic [NCW-1:0] n [3];
  logic [SCW-1:0] s [3];
  logic [SCW-1:0] smax [3];
  logic [XW-1:0]  edge_e;
  logic [RW-1:0]  pos_m [3];
  logic           ge [3];
  logic           all_done, any_over;

  function automatic logic [NCW-1:0] lim_c(input logic [CHUNK_REG_W-1:0] v);
    logic [NCW-1:0] r;
    if (v == '0) r = NCW'(1);
    else if (int'(v) > MAX_CHUNK_AXIS) r = NCW'(MAX_CHUNK_AXIS);
    else r = NCW'(v);
    return r;
  endfunction

  function automatic logic [SCW-1:0] lim_s(input logic [SUB_REG_W-1:0] v);
    logic [SCW-1:0] r;
    if (v == '0) r = SCW'(1);
    else if (int'(v) > MAX_SUB_AXIS) r = SCW'(MAX_SUB_AXIS);
    else r = SCW'(v);
    return r;
  endfunction

  // effective counts and edge
  always_comb begin
    n[0] = lim_c(cfg.chunks_x);
    n[1] = lim_c(cfg.chunks_y);
    n[2] = lim_c(cfg.chunks_z);
    s[0] = lim_s(cfg.subs_x);
    s[1] = lim_s(cfg.subs_y);
    s[2] = lim_s(cfg.subs_z);
    for (int a = 0; a < 3; a++) begin
      smax[a] = s[a] - SCW'(1);
    end
    edge_e = (cfg.cell_edge == '0) ? XW'(1) : XW'(cfg.cell_edge);
    pos_m[0] = RW'(in_item.pos_x[COORD_W-2:0]);
    pos_m[1] = RW'(in_item.pos_y[COORD_W-2:0]);
    pos_m[2] = RW'(in_item.pos_z[COORD_W-2:0]);
  end

  // sequencer: chunk and subcell by repeated subtraction, then slot math
  always_comb begin
    st_nxt    = st_r;
    item_nxt  = item_r;
    rej_nxt   = rej_r;
    rem_nxt   = rem_r;
    c_nxt     = c_r;
    q_nxt     = q_r;
    t_nxt     = t_r;
    u_nxt     = u_r;
    cslot_nxt = cslot_r;
    sslot_nxt = sslot_r;
    idx_nxt   = idx_r;
    push      = 1'b0;
    all_done  = 1'b1;
    any_over  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ge[a] = rem_r[a] >= edge_e;
    end
    case (st_r)
      F_IDLE: begin
        if (start_acc) begin
          item_nxt = in_item;
          for (int a = 0; a < 3; a++) begin
            rem_nxt[a] = XW'(pos_m[a]);
            c_nxt[a]   = '0;
          end
          rej_nxt = ((in_item.mode == MODE_ADD) && !in_item.has_mesh) ||
                    in_item.pos_x[COORD_W-1] || in_item.pos_y[COORD_W-1] ||
                    in_item.pos_z[COORD_W-1];
          st_nxt = rej_nxt ? F_PUSH : F_CHUNK;
        end
      end
      F_CHUNK: begin
        for (int a = 0; a < 3; a++) begin
          if (ge[a] && (c_r[a] != n[a])) begin
            rem_nxt[a] = rem_r[a] - edge_e;
            c_nxt[a]   = c_r[a] + NCW'(1);
            all_done   = 1'b0;
          end
          if (c_r[a] == n[a]) any_over = 1'b1;
        end
        if (all_done) begin
          rej_nxt = any_over;
          st_nxt  = any_over ? F_PUSH : F_SCALE;
        end
      end
      F_SCALE: begin
        for (int a = 0; a < 3; a++) begin
          rem_nxt[a] = XW'(rem_r[a][RW-1:0]) * XW'(s[a]);
          q_nxt[a]   = '0;
        end
        st_nxt = F_SUB;
      end
      F_SUB: begin
        for (int a = 0; a < 3; a++) begin
          if (ge[a] && (q_r[a] != smax[a])) begin
            rem_nxt[a] = rem_r[a] - edge_e;
            q_nxt[a]   = q_r[a] + SCW'(1);
            all_done   = 1'b0;
          end
        end
        if (all_done) st_nxt = F_SLOT1;
      end
      F_SLOT1: begin
        t_nxt  = CSW'(c_r[1]) + CSW'(n[1]) * CSW'(c_r[2]);
        u_nxt  = SSW'(q_r[1]) + SSW'(s[1]) * SSW'(q_r[2]);
        st_nxt = F_SLOT2;
      end
      F_SLOT2: begin
        cslot_nxt = CSW'(c_r[0]) + CSW'(n[0]) * t_r;
        sslot_nxt = SSW'(q_r[0]) + SSW'(s[0]) * u_r;
        st_nxt    = F_IDX;
      end
      F_IDX: begin
        idx_nxt = AW'(cslot_r) * AW'(SUB_CAP) + AW'(sslot_r);
        st_nxt  = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          push   = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  // classified word for the queue
  always_comb begin
    push_data.acc   = !rej_r;
    push_data.add   = item_r.mode == MODE_ADD;
    push_data.cslot = rej_r ? '0 : CHUNK_SLOT_W'(cslot_r);
    push_data.sslot = rej_r ? '0 : SUB_SLOT_W'(sslot_r);
    push_data.box.lo_x = item_r.box_lo_x;
    push_data.box.lo_y = item_r.box_lo_y;
    push_data.box.lo_z = item_r.box_lo_z;
    push_data.box.hi_x = item_r.box_hi_x;
    push_data.box.hi_y = item_r.box_hi_y;
    push_data.box.hi_z = item_r.box_hi_z;
    push_idx = idx_r;
  end

  assign busy = st_r != F_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    rej_r   <= rej_nxt;
    rem_r   <= rem_nxt;
    c_r     <= c_nxt;
    q_r     <= q_nxt;
    t_r     <= t_nxt;
    u_r     <= u_nxt;
    cslot_r <= cslot_nxt;
    sslot_r <= sslot_nxt;
    idx_r   <= idx_nxt;
  end

endmodule

// ----- hw/rtl/gcb_queue.sv -----
module gcb_queue
  import gcb_pkg::*;
#(
  parameter int DW = $bits(cls_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] slot_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  // two-entry ring
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  assign rdata = slot_r[rp_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wdata;
  end

endmodule

// ----- hw/rtl/gcb_back.sv -----
module gcb_back
  import gcb_pkg::*;
#(
  parameter int MAX_CHUNK_AXIS = DEF_MAX_CHUNK_AXIS,
  parameter int MAX_SUB_AXIS   = DEF_MAX_SUB_AXIS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr_req,
  input  logic      q_empty,
  input  cls_t      q_data,
  input  logic [((MAX_CHUNK_AXIS**3)*(MAX_SUB_AXIS**3) > 1 ?
                 $clog2((MAX_CHUNK_AXIS**3)*(MAX_SUB_AXIS**3)) : 1)-1:0] q_idx,
  output logic      pop,
  output logic      clearing,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int CELL_CAP = (MAX_CHUNK_AXIS ** 3) * (MAX_SUB_AXIS ** 3);
  localparam int AW       = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_UPD  = 2'b10
  } bst_t;

  bst_t      st_r, st_nxt;
  cls_t      cur_r;
  logic [AW-1:0] idx_r;
  cell_ent_t mem [CELL_CAP];
  cell_ent_t rd_r;
  logic      clr_r, clr_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      mem_we;
  logic [AW-1:0] mem_waddr;
  cell_ent_t mem_wdata;
  box_t      nb, fin;
  logic      used_aft;

  // min/max union of stored box and new box
  always_comb begin
    nb.lo_x = (rd_r.used && rd_r.box.lo_x < cur_r.box.lo_x) ? rd_r.box.lo_x : cur_r.box.lo_x;
    nb.lo_y = (rd_r.used && rd_r.box.lo_y < cur_r.box.lo_y) ? rd_r.box.lo_y : cur_r.box.lo_y;
    nb.lo_z = (rd_r.used && rd_r.box.lo_z < cur_r.box.lo_z) ? rd_r.box.lo_z : cur_r.box.lo_z;
    nb.hi_x = (rd_r.used && rd_r.box.hi_x > cur_r.box.hi_x) ? rd_r.box.hi_x : cur_r.box.hi_x;
    nb.hi_y = (rd_r.used && rd_r.box.hi_y > cur_r.box.hi_y) ? rd_r.box.hi_y : cur_r.box.hi_y;
    nb.hi_z = (rd_r.used && rd_r.box.hi_z > cur_r.box.hi_z) ? rd_r.box.hi_z : cur_r.box.hi_z;
    used_aft = cur_r.add || rd_r.used;
    fin      = used_aft ? (cur_r.add ? nb : rd_r.box) : '0;
  end

  // control: clearing pass, pop, read-modify-write
  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_r;
    mem_wdata     = '0;
    if (clr_req) begin
      clr_nxt     = 1'b1;
      clr_cnt_nxt = '0;
    end else if (clr_r) begin
      mem_we      = 1'b1;
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(CELL_CAP - 1)) clr_nxt = 1'b0;
    end
    case (st_r)
      B_IDLE: begin
        if (!clr_r && !q_empty) begin
          pop = 1'b1;
          if (!q_data.acc) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end else begin
            st_nxt = B_UPD;
          end
        end
      end
      B_UPD: begin
        if (cur_r.add) begin
          mem_we         = 1'b1;
          mem_waddr      = idx_r;
          mem_wdata.used = 1'b1;
          mem_wdata.box  = nb;
        end
        out_valid_nxt           = 1'b1;
        out_item_nxt.accepted   = 1'b1;
        out_item_nxt.chunk_slot = cur_r.cslot;
        out_item_nxt.sub_slot   = cur_r.sslot;
        out_item_nxt.cell_empty = !used_aft;
        out_item_nxt.cell_lo_x  = fin.lo_x;
        out_item_nxt.cell_lo_y  = fin.lo_y;
        out_item_nxt.cell_lo_z  = fin.lo_z;
        out_item_nxt.cell_hi_x  = fin.hi_x;
        out_item_nxt.cell_hi_y  = fin.hi_y;
        out_item_nxt.cell_hi_z  = fin.hi_z;
        st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  assign clearing  = clr_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (pop) begin
      cur_r <= q_data;
      idx_r <= q_idx;
    end
  end

  // subcell box memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[q_idx];
  end

endmodule

// ----- hw/rtl/grid_cell_binning_bounds_core.sv -----
// Two-level uniform grid binner. A command is taken when start is high and busy is
// low. Its single result appears later on out_item for exactly one cycle with
// out_valid high; the receiver cannot stall it. A front sequencer finds the chunk
// and subcell per axis by repeated subtraction of the cell edge. The chunk search
// is followed by scaling the offset, the subcell search, the slot arithmetic and
// the hand-off to the queue. A command rejected for mesh or sign skips the
// arithmetic and goes straight to the hand-off. A command rejected for lying beyond
// the grid is caught at the end of the chunk search and then handed off. For each
// accepted command the back reads the subcell box memory and, for an add, writes
// the merged box back, overlapped through a two-entry queue, so it never holds up
// the front. After reset and after every write to a valid register the box memory
// is swept clear, one entry per cycle, over all MAX_CHUNK_AXIS^3 * MAX_SUB_AXIS^3
// entries (32768 by default). Busy stays high during the sweep.
module grid_cell_binning_bounds_core
  import gcb_pkg::*;
#(
  parameter int MAX_CHUNK_AXIS = DEF_MAX_CHUNK_AXIS,
  parameter int MAX_SUB_AXIS   = DEF_MAX_SUB_AXIS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELL_CAP = (MAX_CHUNK_AXIS ** 3) * (MAX_SUB_AXIS ** 3);
  localparam int AW       = CELL_CAP > 1 ? $clog2(CELL_CAP) : 1;
  localparam int QW       = $bits(cls_t) + AW;

  grid_cfg_t     cfg_r;
  logic          cfg_clr;
  logic          start_acc;
  logic          f_busy, clearing;
  logic          push, pop, q_full, q_empty;
  cls_t          push_data, q_data;
  logic [AW-1:0] push_idx, q_idx;
  logic [QW-1:0] q_rdata;

  // configuration registers
  assign cfg_clr = cfg_we && (cfg_index <= REG_CELL_EDGE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chunks_x  <= RST_CHUNKS_X;
      cfg_r.chunks_y  <= RST_CHUNKS_Y;
      cfg_r.chunks_z  <= RST_CHUNKS_Z;
      cfg_r.subs_x    <= RST_SUBS_X;
      cfg_r.subs_y    <= RST_SUBS_Y;
      cfg_r.subs_z    <= RST_SUBS_Z;
      cfg_r.cell_edge <= RST_CELL_EDGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHUNKS_X:  cfg_r.chunks_x  <= cfg_data[CHUNK_REG_W-1:0];
        REG_CHUNKS_Y:  cfg_r.chunks_y  <= cfg_data[CHUNK_REG_W-1:0];
        REG_CHUNKS_Z:  cfg_r.chunks_z  <= cfg_data[CHUNK_REG_W-1:0];
        REG_SUBS_X:    cfg_r.subs_x    <= cfg_data[SUB_REG_W-1:0];
        REG_SUBS_Y:    cfg_r.subs_y    <= cfg_data[SUB_REG_W-1:0];
        REG_SUBS_Z:    cfg_r.subs_z    <= cfg_data[SUB_REG_W-1:0];
        REG_CELL_EDGE: cfg_r.cell_edge <= cfg_data[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  // command handshake
  assign busy      = f_busy || clearing;
  assign start_acc = start && !busy;

  gcb_front #(
    .MAX_CHUNK_AXIS(MAX_CHUNK_AXIS),
    .MAX_SUB_AXIS  (MAX_SUB_AXIS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start_acc(start_acc),
    .in_item  (in_item),
    .busy     (f_busy),
    .push     (push),
    .push_data(push_data),
    .push_idx (push_idx),
    .q_full   (q_full)
  );

  gcb_queue #(
    .DW(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata({push_data, push_idx}),
    .pop  (pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  assign q_data = q_rdata[QW-1:AW];
  assign q_idx  = q_rdata[AW-1:0];

  gcb_back #(
    .MAX_CHUNK_AXIS(MAX_CHUNK_AXIS),
    .MAX_SUB_AXIS  (MAX_SUB_AXIS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_req  (cfg_clr),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_idx    (q_idx),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// ----- hw/rtl/gcb_checker.sv -----
module gcb_checker
  import gcb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_item,
  input logic                  out_valid,
  input out_item_t             out_item,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // reset starts the clearing sweep
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // an accepted command makes the block busy
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted command");

  // a valid register write starts a clearing sweep
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index <= REG_CELL_EDGE) |=> busy)
    else $error("busy low after config write");

  // a rejected word carries all zeros
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.accepted) |-> (out_item == '0))
    else $error("rejected word not zero");

  // an empty cell reports a zero box
  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.cell_empty) |->
    (out_item.cell_lo_x == '0 && out_item.cell_lo_y == '0 &&
     out_item.cell_lo_z == '0 && out_item.cell_hi_x == '0 &&
     out_item.cell_hi_y == '0 && out_item.cell_hi_z == '0))
    else $error("empty cell with nonzero box");

endmodule

bind grid_cell_binning_bounds_core gcb_checker u_chk (.*);
